FILE: hdl/pdgtd_pkg.sv
// Shared type, constants and function of the PCM16 difference, gain and dither block.
package pdgtd_pkg;

  localparam int unsigned SMP_W      = 16;
  localparam int unsigned GAIN_W     = 20;
  localparam int unsigned NORM_W     = 42;
  localparam int unsigned NUM_W      = 56;
  localparam int unsigned QUO_W      = 41;
  localparam int unsigned REM_W      = 15;
  localparam int unsigned NORM_STEPS = 28;
  localparam int unsigned NORM_CNT_W = 5;
  localparam int unsigned ACC_W      = 63;
  localparam int unsigned DITH_W     = 25;
  localparam int unsigned DRAW_W     = 24;
  localparam int unsigned PROD_W     = 57;

  localparam logic [REM_W:0]    DIV_DEN    = 16'd32767;
  localparam logic [31:0]       GEN_SEED   = 32'h1234_5678;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 20'd65536;

  typedef enum logic {
    REG_GAIN = 1'b0,
    REG_MUTE = 1'b1
  } reg_idx_e;

  function automatic logic [31:0] xs32_next(input logic [31:0] s);
    logic [31:0] x;
    x = s;
    x = x ^ (x << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    return x;
  endfunction

endpackage

FILE: hdl/pdgtd_norm.sv
// Radix-4 normaliser: divides a non-negative sample by 32767 at 40 fractional bits.
module pdgtd_norm (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic signed [pdgtd_pkg::SMP_W-1:0]    sample_i,
  output logic                                  busy_o,
  output logic signed [pdgtd_pkg::NORM_W-1:0]   value_o
);

  logic                                  busy_q, busy_d;
  logic [pdgtd_pkg::NORM_CNT_W-1:0]      cnt_q, cnt_d;
  logic [pdgtd_pkg::NUM_W-1:0]           num_q, num_d;
  logic [pdgtd_pkg::REM_W-1:0]           rem_q, rem_d;
  logic [pdgtd_pkg::QUO_W-1:0]           quo_q, quo_d;
  logic signed [pdgtd_pkg::SMP_W-1:0]    smp_q, smp_d;
  logic [pdgtd_pkg::REM_W:0]             trial;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    smp_d  = smp_q;
    trial  = '0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      num_d  = {1'b0, sample_i[pdgtd_pkg::SMP_W-2:0], 26'd0, 14'h3FFF};
      rem_d  = '0;
      quo_d  = '0;
      smp_d  = sample_i;
    end else if (busy_q) begin
      for (int k = 0; k < 2; k++) begin
        trial = {rem_d, num_d[pdgtd_pkg::NUM_W-1]};
        num_d = num_d << 1;
        if (trial >= pdgtd_pkg::DIV_DEN) begin
          rem_d = pdgtd_pkg::REM_W'(trial - pdgtd_pkg::DIV_DEN);
          quo_d = {quo_d[pdgtd_pkg::QUO_W-2:0], 1'b1};
        end else begin
          rem_d = trial[pdgtd_pkg::REM_W-1:0];
          quo_d = {quo_d[pdgtd_pkg::QUO_W-2:0], 1'b0};
        end
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == pdgtd_pkg::NORM_CNT_W'(pdgtd_pkg::NORM_STEPS - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    smp_q <= smp_d;
  end

  assign busy_o  = busy_q;
  assign value_o = smp_q[pdgtd_pkg::SMP_W-1]
                   ? (pdgtd_pkg::NORM_W'(smp_q) <<< 25)
                   : $signed({1'b0, quo_q});

endmodule

FILE: hdl/pcm16_diff_gain_tpdf_dither.sv
// Top level of the PCM16 difference filter with gain, TPDF dither, clamp and rounding.
// An unmuted transaction passes through the radix-4 serial divider, the subtraction, the
// shift-add gain multiplier, clamping, rounding and hand-off; the next one is taken after hand-off.
// The result is offered, and the input made ready again, in the same cycle, once any earlier
// result is taken. A muted transaction goes straight to hand-off with a zero result.
// Reset is asynchronous and active low; it restores gain, mute, history and generator.
module pcm16_diff_gain_tpdf_dither (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [pdgtd_pkg::SMP_W-1:0]  sample_in_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [pdgtd_pkg::SMP_W-1:0]  sample_out_o,
  input  logic                                cfg_we_i,
  input  logic                                cfg_idx_i,
  input  logic [pdgtd_pkg::GAIN_W-1:0]        cfg_wdata_i
);

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b000_0000_0001,
    ST_DRAW1 = 11'b000_0000_0010,
    ST_DRAW2 = 11'b000_0000_0100,
    ST_WAIT  = 11'b000_0000_1000,
    ST_SUB   = 11'b000_0001_0000,
    ST_MUL   = 11'b000_0010_0000,
    ST_CLAMP = 11'b000_0100_0000,
    ST_RND16 = 11'b000_1000_0000,
    ST_SCALE = 11'b001_0000_0000,
    ST_RND40 = 11'b010_0000_0000,
    ST_DONE  = 11'b100_0000_0000
  } state_e;

  localparam logic signed [pdgtd_pkg::ACC_W-1:0] AccOne = pdgtd_pkg::ACC_W'(1) << 56;

  state_e                                   state_q, state_d;
  logic [pdgtd_pkg::GAIN_W-1:0]             gain_q, gain_d;
  logic                                     mute_q, mute_d;
  logic [31:0]                              gen_q, gen_d;
  logic signed [pdgtd_pkg::NORM_W-1:0]      prev_q, prev_d;
  logic [4:0]                               cnt_q, cnt_d;
  logic                                     out_valid_q, out_valid_d;

  logic [pdgtd_pkg::DRAW_W-1:0]             r1_q, r1_d;
  logic signed [pdgtd_pkg::DITH_W-1:0]      dith_q, dith_d;
  logic signed [pdgtd_pkg::ACC_W-1:0]       mcand_q, mcand_d;
  logic [pdgtd_pkg::GAIN_W-1:0]             mplier_q, mplier_d;
  logic signed [pdgtd_pkg::ACC_W-1:0]       acc_q, acc_d;
  logic signed [pdgtd_pkg::NORM_W-1:0]      v40_q, v40_d;
  logic signed [pdgtd_pkg::PROD_W-1:0]      p_q, p_d;
  logic signed [pdgtd_pkg::SMP_W-1:0]       y_q, y_d;
  logic signed [pdgtd_pkg::SMP_W-1:0]       out_q, out_d;

  logic                                     norm_start;
  logic                                     norm_busy;
  logic signed [pdgtd_pkg::NORM_W-1:0]      norm_val;
  logic [31:0]                              draw;
  logic signed [pdgtd_pkg::NORM_W:0]        diff;
  logic                                     up16;
  logic                                     up40;

  pdgtd_norm u_norm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (norm_start),
    .sample_i (sample_in_i),
    .busy_o   (norm_busy),
    .value_o  (norm_val)
  );

  assign draw = pdgtd_pkg::xs32_next(gen_q);
  assign diff = $signed({norm_val[pdgtd_pkg::NORM_W-1], norm_val})
              - $signed({prev_q[pdgtd_pkg::NORM_W-1], prev_q});
  assign up16 = (acc_q[15:0] > 16'h8000) || ((acc_q[15:0] == 16'h8000) && acc_q[16]);
  assign up40 = (p_q[39:0] > {1'b1, 39'd0}) || ((p_q[39:0] == {1'b1, 39'd0}) && p_q[40]);

  always_comb begin
    state_d     = state_q;
    gain_d      = gain_q;
    mute_d      = mute_q;
    gen_d       = gen_q;
    prev_d      = prev_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    r1_d        = r1_q;
    dith_d      = dith_q;
    mcand_d     = mcand_q;
    mplier_d    = mplier_q;
    acc_d       = acc_q;
    v40_d       = v40_q;
    p_d         = p_q;
    y_d         = y_q;
    out_d       = out_q;
    norm_start  = 1'b0;

    if (cfg_we_i) begin
      unique case (pdgtd_pkg::reg_idx_e'(cfg_idx_i))
        pdgtd_pkg::REG_GAIN: gain_d = cfg_wdata_i;
        pdgtd_pkg::REG_MUTE: mute_d = cfg_wdata_i[0];
      endcase
    end

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (mute_q) begin
            y_d     = '0;
            state_d = ST_DONE;
          end else begin
            norm_start = 1'b1;
            state_d    = ST_DRAW1;
          end
        end
      end
      ST_DRAW1: begin
        gen_d   = draw;
        r1_d    = draw[pdgtd_pkg::DRAW_W-1:0];
        state_d = ST_DRAW2;
      end
      ST_DRAW2: begin
        gen_d   = draw;
        dith_d  = $signed({1'b0, r1_q}) - $signed({1'b0, draw[pdgtd_pkg::DRAW_W-1:0]});
        state_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (!norm_busy) begin
          state_d = ST_SUB;
        end
      end
      ST_SUB: begin
        prev_d   = norm_val;
        mcand_d  = pdgtd_pkg::ACC_W'(diff);
        mplier_d = gain_q;
        acc_d    = pdgtd_pkg::ACC_W'(dith_q) <<< 17;
        cnt_d    = '0;
        state_d  = ST_MUL;
      end
      ST_MUL: begin
        if (mplier_q[0]) begin
          acc_d = acc_q + mcand_q;
        end
        mcand_d  = mcand_q <<< 1;
        mplier_d = mplier_q >> 1;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == 5'(pdgtd_pkg::GAIN_W - 1)) begin
          state_d = ST_CLAMP;
        end
      end
      ST_CLAMP: begin
        if (acc_q > AccOne) begin
          acc_d = AccOne;
        end else if (acc_q < -AccOne) begin
          acc_d = -AccOne;
        end
        state_d = ST_RND16;
      end
      ST_RND16: begin
        v40_d   = pdgtd_pkg::NORM_W'(acc_q[pdgtd_pkg::ACC_W-1:16] + {46'd0, up16});
        state_d = ST_SCALE;
      end
      ST_SCALE: begin
        p_d     = (pdgtd_pkg::PROD_W'(v40_q) <<< 15) - pdgtd_pkg::PROD_W'(v40_q);
        state_d = ST_RND40;
      end
      ST_RND40: begin
        y_d     = pdgtd_pkg::SMP_W'(p_q[pdgtd_pkg::PROD_W-1:40] + {16'd0, up40});
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_d       = y_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      gain_q      <= pdgtd_pkg::GAIN_RESET;
      mute_q      <= 1'b0;
      gen_q       <= pdgtd_pkg::GEN_SEED;
      prev_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      gain_q      <= gain_d;
      mute_q      <= mute_d;
      gen_q       <= gen_d;
      prev_q      <= prev_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r1_q     <= r1_d;
    dith_q   <= dith_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    acc_q    <= acc_d;
    v40_q    <= v40_d;
    p_q      <= p_d;
    y_q      <= y_d;
    out_q    <= out_d;
  end

  assign in_ready_o   = (state_q == ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_q;

endmodule

FILE: hdl/pdgtd_chk.sv
// Port-level checker for the PCM16 difference, gain and dither block, with its bind.
module pdgtd_chk (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_o,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic signed [pdgtd_pkg::SMP_W-1:0]  sample_out_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(sample_out_o)))
    else $error("Result changed or vanished while its transaction was stalled.");

  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (sample_out_o != -16'sd32768))
    else $error("Result lies outside the symmetric output range.");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("Input was ready again straight after a transaction was taken.");

  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_valid_i && in_ready_o))
    else $error("Result appeared in the cycle right after an input transaction.");

endmodule

bind pcm16_diff_gain_tpdf_dither pdgtd_chk u_pdgtd_chk (.*);
